// ===== design/assert_macros.svh =====
// Assertion macros used by the port-level checker.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property, disabled while reset is asserted.
`define SKHT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("skht assertion failed");

// Signal must hold its value across a cycle in which cond is true.
`define SKHT_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("skht hold check failed");

`endif

// ===== design/skht_pkg.sv =====
// Package for the string key hash table: payload types and status codes.
// Depends on nothing.
package skht_pkg;

    // Width of the running byte sum
    localparam int SUM_W = 16;

    // Result status codes
    localparam logic [1:0] STATUS_INSERTED  = 2'd0;
    localparam logic [1:0] STATUS_OCCUPIED  = 2'd1;
    localparam logic [1:0] STATUS_FOUND     = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    // Key operation
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] key_byte;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
    } t_out;

endpackage

// ===== design/skht_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
module skht_ram #(
    parameter int WIDTH = 8,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [1 << AW];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/skht_rem.sv =====
// Remainder unit: sum modulo SLOTS by reciprocal multiplication, registered in r_x then r_quot.
// Depends on skht_pkg for the sum width.
module skht_rem #(
    parameter int SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [skht_pkg::SUM_W-1:0]      i_dividend,
    output logic                            o_done,
    output logic [$clog2(SLOTS)-1:0]        o_rem
);

    // q = (x * RECIP) >> K is exact for every SUM_W-bit x when
    // K = SUM_W + ceil(log2(SLOTS)) and RECIP = ceil(2^K / SLOTS)
    localparam int XW = skht_pkg::SUM_W;
    localparam int SW = $clog2(SLOTS);
    localparam int DW = SW + 1;
    localparam int K  = XW + SW;
    localparam int MW = XW + 1;
    localparam int PW = XW + MW;
    localparam int QW = PW - K;
    localparam logic [MW-1:0] RECIP =
        MW'(((longint'(1) << K) + longint'(SLOTS) - 1) / longint'(SLOTS));
    localparam logic [DW-1:0] DIVISOR = DW'(SLOTS);

    logic              r_v1;
    logic              r_v2;
    logic [XW-1:0]     r_x;
    logic [QW-1:0]     r_quot;
    logic [PW-1:0]     prod;
    logic [SW-1:0]     back;

    // Quotient estimate, then remainder from the low bits only
    assign prod  = r_x * RECIP;
    assign back  = SW'(r_quot * DIVISOR);
    assign o_rem = r_x[SW-1:0] - back;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dividend;
        end
        if (r_v1) begin
            r_quot <= QW'(prod >> K);
        end
    end

    assign o_done = r_v2;

endmodule

// ===== design/string_key_hash_table_unit.sv =====
// String key hash table. Key bytes are taken one per transfer, one per cycle
// while the block is collecting. After the last byte the 16-bit byte sum is
// reduced modulo SLOTS by a reciprocal multiplication, then the DECIDE state
// picks the action. An insert into a free slot copies the received key from
// the key buffer RAM into the slot's row of the key store RAM, one byte per
// cycle through the registered read port, then writes the length (capped at
// KEY_BYTES). A lookup of an occupied slot reads the stored length, then
// compares both RAMs byte by byte. From the transfer of the last byte,
// intake is paused until the result is loaded into the output register.
// The result sits in an output register, so bytes of the next key are taken
// while it waits; a later result waits only while that register is still
// full. The occupied flags are flops cleared by reset; the RAMs need no
// clearing pass.
module string_key_hash_table_unit #(
    parameter int SLOTS     = 16,
    parameter int KEY_BYTES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  skht_pkg::t_in i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output skht_pkg::t_out o_out_data
);

    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = $clog2(KEY_BYTES + 1);
    localparam int AWI   = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int ST_AW = SW + LW;
    localparam logic [LW-1:0] LEN_COL = LW'(KEY_BYTES);

    // Controller states
    localparam logic [2:0] ST_COLLECT = 3'd0;
    localparam logic [2:0] ST_HASH    = 3'd1;
    localparam logic [2:0] ST_DECIDE  = 3'd2;
    localparam logic [2:0] ST_COPY    = 3'd3;
    localparam logic [2:0] ST_LEN_CHK = 3'd4;
    localparam logic [2:0] ST_CMP     = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    logic [2:0]                 r_state;
    logic [skht_pkg::SUM_W-1:0] r_sum;
    logic [LW-1:0]              r_count;
    logic                       r_mode;
    logic [LW-1:0]              r_klen;
    logic [SW-1:0]              r_slot;
    logic [LW-1:0]              r_idx;
    logic                       r_rd_v;
    logic [LW-1:0]              r_rd_idx;
    logic                       r_mismatch;
    logic [1:0]                 r_status;
    logic [SLOTS-1:0]           r_occ;
    logic                       r_out_valid;
    skht_pkg::t_out             r_out;

    logic                       in_fire;
    logic                       byte_ok;
    logic [skht_pkg::SUM_W-1:0] n_sum;
    logic [LW-1:0]              n_count;
    logic                       issue;
    logic                       pass_end;
    logic                       rem_start;
    logic                       rem_done;
    logic [SW-1:0]              rem_val;

    logic                       in_we;
    logic [7:0]                 in_rdata;
    logic                       st_we;
    logic [ST_AW-1:0]           st_waddr;
    logic [7:0]                 st_wdata;
    logic [ST_AW-1:0]           st_raddr;
    logic [7:0]                 st_rdata;

    // Byte intake; bytes past KEY_BYTES are dropped
    assign o_in_ready = (r_state == ST_COLLECT);
    assign in_fire    = i_in_valid && o_in_ready;
    assign byte_ok    = (r_count < LEN_COL);
    assign n_sum      = byte_ok ? (r_sum + skht_pkg::SUM_W'(i_in_data.key_byte)) : r_sum;
    assign n_count    = byte_ok ? (r_count + 1'b1) : r_count;
    assign in_we      = in_fire && byte_ok;
    assign rem_start  = in_fire && i_in_data.last;

    // Copy / compare pass: issue reads up to the key length, then drain the last read
    assign issue    = (r_idx != r_klen);
    assign pass_end = !issue && !r_rd_v;

    // Key store accesses. Copy only writes, compare only reads, so the same
    // entry is never read and written in overlapping cycles.
    assign st_raddr = (r_state == ST_DECIDE) ? {r_slot, LEN_COL} : {r_slot, r_idx};

    always_comb begin
        st_we    = 1'b0;
        st_waddr = {r_slot, r_rd_idx};
        st_wdata = in_rdata;
        if (r_state == ST_COPY) begin
            if (r_rd_v) begin
                st_we = 1'b1;
            end else if (!issue) begin
                st_we    = 1'b1;
                st_waddr = {r_slot, LEN_COL};
                st_wdata = 8'(r_klen);
            end
        end
    end

    // Buffer for the key being received
    skht_ram #(
        .WIDTH (8),
        .AW    (AWI)
    ) u_inbuf (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (r_count[AWI-1:0]),
        .i_wdata (i_in_data.key_byte),
        .i_raddr (r_idx[AWI-1:0]),
        .o_rdata (in_rdata)
    );

    // Key store: one row per slot, length kept in the column after the bytes
    skht_ram #(
        .WIDTH (8),
        .AW    (ST_AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // Slot hash
    skht_rem #(
        .SLOTS (SLOTS)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (n_sum),
        .o_done     (rem_done),
        .o_rem      (rem_val)
    );

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_sum       <= '0;
            r_count     <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
            r_rd_v      <= 1'b0;
        end else begin
            // Result register: load from DONE, clear once taken
            if ((r_state == ST_DONE) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_COLLECT: begin
                    if (in_fire) begin
                        if (i_in_data.last) begin
                            r_sum   <= '0;
                            r_count <= '0;
                            r_state <= ST_HASH;
                        end else begin
                            r_sum   <= n_sum;
                            r_count <= n_count;
                        end
                    end
                end
                ST_HASH: begin
                    if (rem_done) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_rd_v <= 1'b0;
                    if (r_mode == skht_pkg::MODE_INSERT) begin
                        r_state <= r_occ[r_slot] ? ST_DONE : ST_COPY;
                    end else begin
                        r_state <= r_occ[r_slot] ? ST_LEN_CHK : ST_DONE;
                    end
                end
                ST_COPY: begin
                    r_rd_v <= issue;
                    if (pass_end) begin
                        r_occ[r_slot] <= 1'b1;
                        r_state       <= ST_DONE;
                    end
                end
                ST_LEN_CHK: begin
                    r_state <= (st_rdata[LW-1:0] == r_klen) ? ST_CMP : ST_DONE;
                end
                ST_CMP: begin
                    r_rd_v <= issue;
                    if (pass_end) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= ST_COLLECT;
                    end
                end
                default: begin
                    r_state <= ST_COLLECT;
                end
            endcase
        end
    end

    // Key context, pass indexes and status
    always_ff @(posedge i_clk) begin
        if (rem_start) begin
            r_klen <= n_count;
            r_mode <= i_in_data.mode;
        end
        if (rem_done) begin
            r_slot <= rem_val;
        end
        case (r_state)
            ST_DECIDE: begin
                r_idx      <= '0;
                r_mismatch <= 1'b0;
                if (r_mode == skht_pkg::MODE_INSERT) begin
                    r_status <= skht_pkg::STATUS_OCCUPIED;
                end else begin
                    r_status <= skht_pkg::STATUS_NOT_FOUND;
                end
            end
            ST_COPY: begin
                if (issue) begin
                    r_idx    <= r_idx + 1'b1;
                    r_rd_idx <= r_idx;
                end
                if (pass_end) begin
                    r_status <= skht_pkg::STATUS_INSERTED;
                end
            end
            ST_CMP: begin
                if (issue) begin
                    r_idx    <= r_idx + 1'b1;
                    r_rd_idx <= r_idx;
                end
                if (r_rd_v && (st_rdata != in_rdata)) begin
                    r_mismatch <= 1'b1;
                end
                if (pass_end) begin
                    r_status <= r_mismatch ? skht_pkg::STATUS_NOT_FOUND
                                           : skht_pkg::STATUS_FOUND;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out.status <= r_status;
                    r_out.slot   <= 4'(r_slot);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== design/skht_chk.sv =====
// Port-level checker for the string key hash table, bound to the top level.
// Depends on skht_pkg and assert_macros.svh.
`include "assert_macros.svh"

module skht_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input skht_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input skht_pkg::t_out o_out_data
);

    // Stalled result stays offered and unchanged
    `SKHT_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> o_out_valid)
    `SKHT_ASSERT_HOLD(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_data)

    // Transfer of a final byte starts the slot pass, so intake pauses
    `SKHT_ASSERT(a_last_busy, i_clk, i_rst_n, (i_in_valid && o_in_ready && i_in_data.last) |=> !o_in_ready)

    // A new result only appears while intake is paused
    `SKHT_ASSERT(a_res_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> !$past(o_in_ready))

endmodule

bind string_key_hash_table_unit skht_chk u_skht_chk (.*);

// ===== sim/string_key_hash_table_unit_checker.sv =====
// Checker for the string key hash table: watches both channels, keeps its own
// copy of the table and compares every reply with the expected one.
// Depends on skht_pkg for the payload types and status codes.
module string_key_hash_table_unit_checker #(
    parameter int SLOTS     = 16,
    parameter int KEY_BYTES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  skht_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  skht_pkg::t_out i_out_data,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_status_tally [4]
);
    timeunit 1ns;
    timeprecision 1ps;

    // Table image
    logic [7:0]  stored_key [SLOTS][KEY_BYTES];
    logic [6:0]  stored_len [SLOTS];
    logic        slot_taken [SLOTS];

    // Key being received
    logic [7:0]  rx_key [KEY_BYTES];
    logic [15:0] byte_sum;
    logic [6:0]  rx_count;

    skht_pkg::t_out expected_replies [$];
    int             reply_index;

    // Absorb one key byte; on the last byte resolve the insert or lookup.
    function automatic bit hash_table_step(input skht_pkg::t_in item,
                                           output skht_pkg::t_out reply);
        int unsigned idx;
        bit          same;
        reply = '0;
        // bytes past the key buffer neither hash nor compare
        if (rx_count < KEY_BYTES) begin
            rx_key[rx_count] = item.key_byte;
            byte_sum         = byte_sum + 16'(item.key_byte);
            rx_count         = rx_count + 7'd1;
        end
        if (!item.last) begin
            return 1'b0;
        end
        idx = byte_sum % SLOTS;
        if (item.mode == skht_pkg::MODE_INSERT) begin
            if (slot_taken[idx]) begin
                reply.status = skht_pkg::STATUS_OCCUPIED;
            end else begin
                for (int i = 0; i < rx_count; i++) begin
                    stored_key[idx][i] = rx_key[i];
                end
                stored_len[idx] = rx_count;
                slot_taken[idx] = 1'b1;
                reply.status    = skht_pkg::STATUS_INSERTED;
            end
        end else begin
            // empty slot or length mismatch is a miss
            same = slot_taken[idx] && (stored_len[idx] == rx_count);
            for (int i = 0; same && i < rx_count; i++) begin
                if (stored_key[idx][i] != rx_key[i]) begin
                    same = 1'b0;
                end
            end
            reply.status = same ? skht_pkg::STATUS_FOUND : skht_pkg::STATUS_NOT_FOUND;
        end
        reply.slot = idx[3:0];
        byte_sum   = '0;
        rx_count   = '0;
        return 1'b1;
    endfunction

    // Predict on each input transfer, compare on each output transfer
    always @(posedge i_clk) begin
        skht_pkg::t_out reply;
        skht_pkg::t_out want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                slot_taken[s] = 1'b0;
            end
            byte_sum     = '0;
            rx_count     = '0;
            reply_index  = 0;
            o_fail_count = 0;
            for (int k = 0; k < 4; k++) begin
                o_status_tally[k] = 0;
            end
            expected_replies.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("unexpected reply %0d: status %0d slot %0d",
                                 reply_index, i_out_data.status, i_out_data.slot);
                    end
                end else begin
                    want = expected_replies.pop_front();
                    if (i_out_data.status !== want.status || i_out_data.slot !== want.slot) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("reply %0d mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                                     reply_index, want.status, want.slot,
                                     i_out_data.status, i_out_data.slot);
                        end
                    end
                    o_status_tally[want.status]++;
                end
                reply_index++;
            end
            if (i_in_valid && i_in_ready && hash_table_step(i_in_data, reply)) begin
                expected_replies.push_back(reply);
            end
        end
        o_pending = expected_replies.size();
    end

endmodule

// ===== sim/string_key_hash_table_unit_tb.sv =====
// Testbench top for the string key hash table: clock, reset, key stimulus,
// reply back-pressure and the verdict. Depends on skht_pkg, the block and
// string_key_hash_table_unit_checker.
module string_key_hash_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 16;
    localparam int KEY_BYTES    = 64;
    localparam int MAX_KEY      = 80;
    localparam int BANK         = 32;
    localparam int RANDOM_BYTES = 625;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 600000;

    logic           i_clk;
    logic           i_rst_n   = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    skht_pkg::t_in  in_data   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    skht_pkg::t_out out_data;

    int   fail_count;
    int   pending;
    int   status_tally [4];

    // Key under construction and a bank of inserted keys for replays
    logic [7:0] key_buf [MAX_KEY];
    int         key_len;
    logic [7:0] bank_bytes [BANK][MAX_KEY];
    int         bank_len [BANK];
    int         bank_count = 0;

    int         keys_sent  = 0;
    int         bytes_sent = 0;
    int         longest    = 0;
    int         send_quiet = 0;
    bit         calm       = 1'b0;

    string_key_hash_table_unit #(
        .SLOTS     (SLOTS),
        .KEY_BYTES (KEY_BYTES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    string_key_hash_table_unit_checker #(
        .SLOTS     (SLOTS),
        .KEY_BYTES (KEY_BYTES)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_status_tally (status_tally)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Fill the key buffer: two leading bytes, the rest a constant
    task automatic make_key(input int len, input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] fill);
        key_len = len;
        for (int i = 0; i < len; i++) begin
            key_buf[i] = (i == 0) ? b0 : (i == 1) ? b1 : fill;
        end
    endtask

    // Send the buffered key; the last byte carries last_mode, the others body_mode
    task automatic send_key(input logic last_mode, input logic body_mode);
        bit   taken;
        logic is_last;
        for (int i = 0; i < key_len; i++) begin
            is_last = (i == key_len - 1);
            in_valid <= 1'b1;
            in_data  <= '{mode: is_last ? last_mode : body_mode, key_byte: key_buf[i],
                          last: is_last};
            // ready is stable by the falling edge
            taken = 1'b0;
            while (!taken) begin
                @(negedge i_clk);
                taken = in_ready;
                @(posedge i_clk);
            end
            bytes_sent++;
            // random sender gaps, separated by runs without any
            if (!calm && send_quiet == 0 && $urandom_range(0, 3) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                send_quiet = $urandom_range(0, 30);
            end else if (send_quiet > 0) begin
                send_quiet--;
            end
        end
        if (last_mode == skht_pkg::MODE_INSERT) begin
            for (int i = 0; i < key_len; i++) begin
                bank_bytes[bank_count % BANK][i] = key_buf[i];
            end
            bank_len[bank_count % BANK] = key_len;
            bank_count++;
        end
        keys_sent++;
        if (key_len > longest) begin
            longest = key_len;
        end
    endtask

    // Hold the sender off until every reply is back
    task automatic wait_for_replies();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // Reply back-pressure in random bursts
    initial begin
        int quiet;
        quiet = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!calm && quiet == 0 && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                quiet = $urandom_range(0, 20);
            end else begin
                out_ready <= 1'b1;
                if (quiet > 0) begin
                    quiet--;
                end
                @(posedge i_clk);
            end
        end
    end

    // Watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("FAIL string_key_hash_table_unit");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        int   pick;
        int   src;
        int   a;
        int   b;
        int   random_bytes;
        bit   paused;
        logic last_mode;
        logic body_mode;
        logic [7:0] swap;

        random_bytes = 0;
        paused       = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty slot, hit, collision, length and content misses
        make_key(1, 8'h41, 8'h00, 8'h00);
        send_key(skht_pkg::MODE_LOOKUP, skht_pkg::MODE_LOOKUP);
        send_key(skht_pkg::MODE_INSERT, skht_pkg::MODE_INSERT);
        send_key(skht_pkg::MODE_LOOKUP, skht_pkg::MODE_LOOKUP);
        make_key(2, 8'h31, 8'h10, 8'h00);
        send_key(skht_pkg::MODE_INSERT, skht_pkg::MODE_INSERT);
        make_key(2, 8'h10, 8'h31, 8'h00);
        send_key(skht_pkg::MODE_LOOKUP, skht_pkg::MODE_LOOKUP);
        make_key(2, 8'h41, 8'h42, 8'h00);
        send_key(skht_pkg::MODE_INSERT, skht_pkg::MODE_INSERT);
        make_key(2, 8'h42, 8'h41, 8'h00);
        send_key(skht_pkg::MODE_LOOKUP, skht_pkg::MODE_LOOKUP);
        // largest byte value, zero byte as data
        make_key(1, 8'hFF, 8'h00, 8'h00);
        send_key(skht_pkg::MODE_INSERT, skht_pkg::MODE_INSERT);
        send_key(skht_pkg::MODE_LOOKUP, skht_pkg::MODE_LOOKUP);
        make_key(2, 8'h00, 8'h05, 8'h00);
        send_key(skht_pkg::MODE_INSERT, skht_pkg::MODE_INSERT);
        send_key(skht_pkg::MODE_LOOKUP, skht_pkg::MODE_LOOKUP);
        // mode flips inside a key: the last byte decides
        make_key(2, 8'h07, 8'h09, 8'h00);
        send_key(skht_pkg::MODE_INSERT, skht_pkg::MODE_LOOKUP);
        send_key(skht_pkg::MODE_LOOKUP, skht_pkg::MODE_INSERT);
        // overlong key: tail past the buffer is dropped
        make_key(70, 8'h01, 8'h02, 8'h84);
        send_key(skht_pkg::MODE_INSERT, skht_pkg::MODE_INSERT);
        key_buf[66] = 8'h11;
        send_key(skht_pkg::MODE_LOOKUP, skht_pkg::MODE_LOOKUP);
        make_key(KEY_BYTES, 8'h01, 8'h02, 8'h84);
        send_key(skht_pkg::MODE_LOOKUP, skht_pkg::MODE_LOOKUP);
        wait_for_replies();

        // Random keys: fresh, replayed, permuted and resized
        while (random_bytes < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 40 || bank_count == 0) begin
                a = $urandom_range(0, 99);
                key_len = (a < 80) ? $urandom_range(1, 8) :
                          (a < 97) ? $urandom_range(9, KEY_BYTES) :
                                     $urandom_range(KEY_BYTES + 1, MAX_KEY);
                for (int i = 0; i < key_len; i++) begin
                    key_buf[i] = 8'($urandom_range(1, 255));
                end
            end else begin
                src = $urandom_range(0, ((bank_count < BANK) ? bank_count : BANK) - 1);
                key_len = bank_len[src];
                for (int i = 0; i < key_len; i++) begin
                    key_buf[i] = bank_bytes[src][i];
                end
                if (pick >= 70 && pick < 85 && key_len > 1) begin
                    // same sum, same length, likely different content
                    a = $urandom_range(0, ((key_len < KEY_BYTES) ? key_len : KEY_BYTES) - 1);
                    b = $urandom_range(0, ((key_len < KEY_BYTES) ? key_len : KEY_BYTES) - 1);
                    swap       = key_buf[a];
                    key_buf[a] = key_buf[b];
                    key_buf[b] = swap;
                end else if (pick >= 85) begin
                    if (key_len > 1 && $urandom_range(0, 1) == 1) begin
                        key_len--;
                    end else if (key_len < MAX_KEY) begin
                        key_buf[key_len] = 8'($urandom_range(1, 255));
                        key_len++;
                    end
                end else if ($urandom_range(0, 3) == 0) begin
                    key_buf[$urandom_range(0, key_len - 1)] = 8'($urandom_range(1, 255));
                end
            end
            last_mode = ($urandom_range(0, 9) < 4) ? skht_pkg::MODE_INSERT
                                                    : skht_pkg::MODE_LOOKUP;
            body_mode = ($urandom_range(0, 9) == 0) ? ~last_mode : last_mode;
            send_key(last_mode, body_mode);
            random_bytes += key_len;
            if (!paused && random_bytes >= RANDOM_BYTES / 2) begin
                wait_for_replies();
                paused = 1'b1;
            end
            if (random_bytes >= RANDOM_BYTES * 4 / 5) begin
                calm = 1'b1;
            end
        end

        // Drain
        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d keys in %0d byte transfers, longest key %0d bytes",
                 keys_sent, bytes_sent, longest);
        $display("replies: %0d inserted, %0d occupied, %0d found, %0d not found",
                 status_tally[skht_pkg::STATUS_INSERTED],
                 status_tally[skht_pkg::STATUS_OCCUPIED],
                 status_tally[skht_pkg::STATUS_FOUND],
                 status_tally[skht_pkg::STATUS_NOT_FOUND]);
        if (fail_count == 0) begin
            $display("PASS string_key_hash_table_unit");
        end else begin
            $display("%0d failures", fail_count);
            $display("FAIL string_key_hash_table_unit");
        end
        $finish;
    end

endmodule
